// ===== sv/bi_pkg.sv =====
// Package for the row-column block interleaver.
// Holds sizes, register indexes, the job descriptor and the shared structs.
// No dependencies.
package bi_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int LEN_W = 7;
  localparam int BYTE_W = 8;
  localparam int STEP_W = $clog2(LEN_W);
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VECTOR_LENGTH = 2'd0,
    REG_BLOCK_LENGTH  = 2'd1,
    REG_MODE          = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_INTERLEAVE   = 1'b0,
    MODE_DEINTERLEAVE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SETUP,
    B_RUN
  } back_state_t;

  typedef struct packed {
    logic             bank;
    mode_t            mode;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] blk;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W:0]   addr;
    logic [BYTE_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              pass;
  } out_t;

endpackage

// ===== sv/bi_front.sv =====
// Front end of the interleaver: configuration registers, input acceptance,
// store writes into the loading bank and job descriptors. Uses bi_pkg.
module bi_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bi_pkg::LEN_W-1:0]       cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bi_pkg::BYTE_W-1:0]      in_byte,
  input  logic                           q_full,
  output logic                           push,
  output bi_pkg::desc_t                  push_desc,
  output bi_pkg::wr_t                    wr
);

  logic [bi_pkg::LEN_W-1:0] vector_length;
  logic [bi_pkg::LEN_W-1:0] block_length;
  bi_pkg::mode_t            mode;
  logic [bi_pkg::LEN_W-1:0] load_count;
  logic [bi_pkg::LEN_W-1:0] load_count_next;
  logic                     bank;
  logic [bi_pkg::LEN_W-1:0] eff_len;
  logic                     accept;
  logic                     done;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= bi_pkg::LEN_W'(bi_pkg::MAX_LEN);
      block_length  <= bi_pkg::LEN_W'(8);
      mode          <= bi_pkg::MODE_INTERLEAVE;
    end else if (cfg_write) begin
      case (bi_pkg::reg_idx_t'(cfg_index))
        bi_pkg::REG_VECTOR_LENGTH: vector_length <= cfg_data;
        bi_pkg::REG_BLOCK_LENGTH:  block_length <= cfg_data;
        bi_pkg::REG_MODE:          mode <= bi_pkg::mode_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vector_length == '0) begin
      eff_len = bi_pkg::LEN_W'(1);
    end else if (vector_length > bi_pkg::LEN_W'(bi_pkg::MAX_LEN)) begin
      eff_len = bi_pkg::LEN_W'(bi_pkg::MAX_LEN);
    end else begin
      eff_len = vector_length;
    end
  end

  assign in_stall = q_full;
  assign accept = in_valid && !in_stall;
  assign load_count_next = load_count + bi_pkg::LEN_W'(1);
  assign done = accept && (load_count_next >= eff_len);

  assign wr.en = accept;
  assign wr.addr = {bank, load_count[bi_pkg::ADDR_W-1:0]};
  assign wr.data = in_byte;

  assign push = done;
  assign push_desc.bank = bank;
  assign push_desc.mode = mode;
  assign push_desc.len = eff_len;
  assign push_desc.blk = block_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      bank <= 1'b0;
    end else if (accept) begin
      if (done) begin
        load_count <= '0;
        bank <= !bank;
      end else begin
        load_count <= load_count_next;
      end
    end
  end

endmodule

// ===== sv/bi_queue.sv =====
// Two-entry job queue between the front and back ends.
// An entry stays until the back end has read its whole vector. Uses bi_pkg.
module bi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bi_pkg::desc_t push_desc,
  input  logic          pop,
  output bi_pkg::desc_t head,
  output logic          nonempty,
  output logic          full
);

  bi_pkg::desc_t entries [bi_pkg::QDEPTH];
  logic          wp;
  logic          rp;
  logic [1:0]    count;

  assign head = entries[rp];
  assign nonempty = (count != 2'd0);
  assign full = (count == 2'(bi_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("job popped from an empty queue");
  a_push_pop_count: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not follow a push");

endmodule

// ===== sv/bi_back.sv =====
// Back end of the interleaver: the double-banked vector store, a bit-serial
// divider for the row count, the permuted address walk and the output buffer.
// Uses bi_pkg.
module bi_back (
  input  logic                      clk,
  input  logic                      rst,
  input  bi_pkg::wr_t               wr,
  input  bi_pkg::desc_t             job,
  input  logic                      q_nonempty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bi_pkg::BYTE_W-1:0] out_byte,
  output logic                      last,
  output logic                      passed_through
);

  logic [bi_pkg::BYTE_W-1:0] mem [2*bi_pkg::MAX_LEN];

  bi_pkg::back_state_t       state;
  bi_pkg::back_state_t       state_next;
  logic [bi_pkg::LEN_W:0]    rem;
  logic [bi_pkg::LEN_W-1:0]  quo;
  logic [bi_pkg::STEP_W-1:0] step;
  logic [bi_pkg::LEN_W:0]    div_try;
  logic                      div_fit;
  logic                      pass;
  logic [bi_pkg::LEN_W-1:0]  stride;
  logic [bi_pkg::LEN_W-1:0]  wrap;
  logic [bi_pkg::ADDR_W-1:0] idx;
  logic [bi_pkg::ADDR_W-1:0] col;
  logic [bi_pkg::LEN_W-1:0]  bcnt;
  logic [bi_pkg::LEN_W-1:0]  z;
  logic                      z_last;
  logic                      issue;
  logic                      slot_free;

  logic [bi_pkg::BYTE_W-1:0] rdata;
  logic                      rd_vld;
  logic                      rd_last;
  logic                      rd_pass;

  bi_pkg::out_t              ofifo [2];
  logic                      owp;
  logic                      orp;
  logic [1:0]                ocount;
  logic                      opop;
  logic [2:0]                occ;

  assign div_try = {rem[bi_pkg::LEN_W-1:0], job.len[step]};
  assign div_fit = (div_try >= {1'b0, job.blk});
  assign z_last = (z == job.len - bi_pkg::LEN_W'(1));

  assign opop = (ocount != 2'd0) && !out_stall;
  assign occ = {1'b0, ocount} + {2'b0, rd_vld} - {2'b0, opop};
  assign slot_free = (occ < 3'd2);

  always_comb begin
    state_next = state;
    case (state)
      bi_pkg::B_IDLE: begin
        if (q_nonempty) begin
          state_next = bi_pkg::B_DIV;
        end
      end
      bi_pkg::B_DIV: begin
        if (step == '0) begin
          state_next = bi_pkg::B_SETUP;
        end
      end
      bi_pkg::B_SETUP: begin
        state_next = bi_pkg::B_RUN;
      end
      bi_pkg::B_RUN: begin
        if (slot_free && z_last) begin
          state_next = bi_pkg::B_IDLE;
        end
      end
      default: state_next = bi_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    issue = 1'b0;
    case (state)
      bi_pkg::B_RUN: issue = slot_free;
      default:       issue = 1'b0;
    endcase
    pop = issue && z_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bi_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bi_pkg::B_IDLE: begin
        rem <= '0;
        quo <= '0;
        step <= bi_pkg::STEP_W'(bi_pkg::LEN_W - 1);
      end
      bi_pkg::B_DIV: begin
        if (div_fit) begin
          rem <= div_try - {1'b0, job.blk};
          quo[step] <= 1'b1;
        end else begin
          rem <= div_try;
        end
        step <= step - bi_pkg::STEP_W'(1);
      end
      bi_pkg::B_SETUP: begin
        pass <= (job.blk == '0) || (rem != '0);
        if ((job.blk == '0) || (rem != '0)) begin
          stride <= bi_pkg::LEN_W'(1);
          wrap <= job.len;
        end else if (job.mode == bi_pkg::MODE_INTERLEAVE) begin
          stride <= job.blk;
          wrap <= quo;
        end else begin
          stride <= quo;
          wrap <= job.blk;
        end
        idx <= '0;
        col <= '0;
        bcnt <= '0;
        z <= '0;
      end
      bi_pkg::B_RUN: begin
        if (issue) begin
          z <= z + bi_pkg::LEN_W'(1);
          if (bcnt == wrap - bi_pkg::LEN_W'(1)) begin
            bcnt <= '0;
            col <= col + bi_pkg::ADDR_W'(1);
            idx <= col + bi_pkg::ADDR_W'(1);
          end else begin
            bcnt <= bcnt + bi_pkg::LEN_W'(1);
            idx <= bi_pkg::ADDR_W'({1'b0, idx} + stride);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= mem[{job.bank, idx}];
      rd_last <= z_last;
      rd_pass <= pass;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      ofifo[owp] <= '{data: rdata, last: rd_last, pass: rd_pass};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      owp <= 1'b0;
      orp <= 1'b0;
      ocount <= '0;
    end else begin
      rd_vld <= issue;
      if (rd_vld) begin
        owp <= !owp;
      end
      if (opop) begin
        orp <= !orp;
      end
      ocount <= ocount + {1'b0, rd_vld} - {1'b0, opop};
    end
  end

  assign out_valid = (ocount != 2'd0);
  assign out_byte = ofifo[orp].data;
  assign last = ofifo[orp].last;
  assign passed_through = ofifo[orp].pass;

  a_idx_in_vector: assert property (@(posedge clk) disable iff (rst)
    issue |-> ({1'b0, idx} < job.len))
    else $error("store read outside the current vector");
  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, ocount} + {2'b0, rd_vld}) <= 3'd2)
    else $error("output buffer over-committed");
  a_run_has_job: assert property (@(posedge clk) disable iff (rst)
    state == bi_pkg::B_RUN |-> q_nonempty)
    else $error("address walk running without a queued job");

endmodule

// ===== sv/block_interleaver.sv =====
// Top level of the row-column block interleaver.
// Connects bi_front, bi_queue and bi_back; uses bi_pkg.
//
// Channel   Signals                                   Direction
// config    cfg_write, cfg_index, cfg_data            in
// input     in_valid, in_stall, in_byte               in (stall out)
// output    out_valid, out_stall, out_byte, last,     out (stall in)
//           passed_through
//
// One input word is taken per cycle while a store bank is free.
// A queued vector waits in the back end for job pickup, the row-count division and setup,
// then one word is read per cycle while the output buffer has room, through the read register and output buffer.
// The store has two banks, so one vector loads while the previous one drains.
// Reset clears the counters and sets length 64, block 8, interleave; the store
// is not cleared. in_stall is high while both banks hold vectors not yet read.
module block_interleaver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bi_pkg::LEN_W-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bi_pkg::BYTE_W-1:0]     in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bi_pkg::BYTE_W-1:0]     out_byte,
  output logic                          last,
  output logic                          passed_through
);

  logic          q_full;
  logic          q_nonempty;
  logic          push;
  logic          pop;
  bi_pkg::desc_t push_desc;
  bi_pkg::desc_t head;
  bi_pkg::wr_t   wr;

  bi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .wr        (wr)
  );

  bi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .nonempty  (q_nonempty),
    .full      (q_full)
  );

  bi_back u_back (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .job            (head),
    .q_nonempty     (q_nonempty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .last           (last),
    .passed_through (passed_through)
  );

endmodule
